/* rtl/core/sha_pkg.sv */
`timescale 1ns / 1ps
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

/* rtl/core/sha256_message_hasher.sv */
`timescale 1ns / 1ps
// Input items are taken while the hasher is idle; an item that fills the 64-byte block holds
// off the input while the single round unit loads, runs 64 rounds and folds the chain. A last
// item adds one or two padding compressions, then eight digest items follow, one per cycle as
// the output is taken.
module sha256_message_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero fill
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_tlast    // last_of_digest
);

    sha_pkg::state_t state_reg, state_next;
    logic [31:0]  buf_reg [16];
    logic [31:0]  spill_reg;
    logic [1:0]   spill_cnt_reg;
    logic [5:0]   fill_reg;
    logic [63:0]  len_reg;
    logic         last_reg;
    logic         second_reg;
    logic         mark_reg;
    logic [2:0]   idx_reg;
    logic [511:0] blk;
    logic [255:0] chain;
    logic         core_done;
    sha_pkg::core_ctl_t ctl;
    logic [2:0]   cnt;
    logic [6:0]   fill_sum;
    logic [6:0]   byte_pos [4];
    logic         put_len;
    logic         acc;

    assign acc = s_tvalid && s_tready;
    assign cnt = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
    assign fill_sum = {1'b0, fill_reg} + {4'd0, cnt};
    assign put_len = mark_reg || (fill_reg < 6'd56);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            byte_pos[i] = {1'b0, fill_reg} + 7'(i);
        end
    end

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            blk[511 - 32*k -: 32] = buf_reg[k];
        end
    end

    sha_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (ctl.start),
        .init_chain (ctl.done),
        .block      (blk),
        .done       (core_done),
        .chain      (chain)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                if (acc) begin
                    if (fill_sum[6]) begin
                        state_next = sha_pkg::ST_LOAD;
                    end else if (s_tlast) begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_LOAD:  state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND: if (core_done) state_next = sha_pkg::ST_FOLD;
            sha_pkg::ST_FOLD: begin
                if (!last_reg) begin
                    state_next = sha_pkg::ST_IDLE;
                end else if (second_reg) begin
                    state_next = sha_pkg::ST_OUT;
                end else begin
                    state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD:   state_next = sha_pkg::ST_LOAD;
            sha_pkg::ST_OUT:   if (m_tready && idx_reg == 3'd7) state_next = sha_pkg::ST_IDLE;
            default:           state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == sha_pkg::ST_IDLE);
        m_tvalid  = (state_reg == sha_pkg::ST_OUT);
        ctl.start = (state_reg == sha_pkg::ST_LOAD);
        ctl.busy  = (state_reg == sha_pkg::ST_ROUND);
        ctl.done  = m_tvalid && m_tready && idx_reg == 3'd7;
    end

    assign m_tdata = {5'd0, idx_reg, chain[{~idx_reg, 5'd0} +: 32]};
    assign m_tlast = (idx_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sha_pkg::ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            last_reg      <= 1'b0;
            second_reg    <= 1'b0;
            mark_reg      <= 1'b0;
            spill_cnt_reg <= '0;
            idx_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (acc) begin
                // Bytes past the end of a full block wait until the block has been loaded.
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < cnt) begin
                        if (byte_pos[i][6]) begin
                            spill_reg[{~byte_pos[i][1:0], 3'd0} +: 8] <= s_tdata[31 - 8*i -: 8];
                        end else begin
                            buf_reg[byte_pos[i][5:2]][{~byte_pos[i][1:0], 3'd0} +: 8]
                                <= s_tdata[31 - 8*i -: 8];
                        end
                    end
                end
                fill_reg      <= fill_sum[5:0];
                spill_cnt_reg <= fill_sum[6] ? fill_sum[1:0] : 2'd0;
                len_reg       <= len_reg + {58'd0, cnt, 3'd0};
                last_reg      <= s_tlast;
                second_reg    <= 1'b0;
                mark_reg      <= 1'b0;
            end
            if (ctl.start) begin
                for (int b = 0; b < 3; b++) begin
                    if (2'(b) < spill_cnt_reg) begin
                        buf_reg[0][31 - 8*b -: 8] <= spill_reg[31 - 8*b -: 8];
                    end
                end
                spill_cnt_reg <= 2'd0;
                if (second_reg) begin
                    fill_reg <= '0;
                end
            end
            if (state_reg == sha_pkg::ST_PAD) begin
                // Pad marker at the fill point, zeros after, length in the last eight bytes
                // when it fits; otherwise this block is padded only and a second follows.
                for (int j = 0; j < 56; j++) begin
                    if (mark_reg) begin
                        buf_reg[j/4][31 - 8*(j%4) -: 8] <= 8'd0;
                    end else if (6'(j) == fill_reg) begin
                        buf_reg[j/4][31 - 8*(j%4) -: 8] <= sha_pkg::PAD_BYTE;
                    end else if (6'(j) > fill_reg) begin
                        buf_reg[j/4][31 - 8*(j%4) -: 8] <= 8'd0;
                    end
                end
                for (int j = 56; j < 64; j++) begin
                    if (put_len) begin
                        buf_reg[j/4][31 - 8*(j%4) -: 8] <= len_reg[63 - 8*(j-56) -: 8];
                    end else if (6'(j) == fill_reg) begin
                        buf_reg[j/4][31 - 8*(j%4) -: 8] <= sha_pkg::PAD_BYTE;
                    end else if (6'(j) > fill_reg) begin
                        buf_reg[j/4][31 - 8*(j%4) -: 8] <= 8'd0;
                    end
                end
                second_reg <= put_len;
                mark_reg   <= 1'b1;
            end
            if (state_reg == sha_pkg::ST_OUT && m_tready) begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    len_reg    <= '0;
                    fill_reg   <= '0;
                    last_reg   <= 1'b0;
                    second_reg <= 1'b0;
                    mark_reg   <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.busy |-> !s_tready) else $error("input taken during rounds");
    a_out_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid) else $error("digest cut short");
    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input during digest");
`endif

endmodule

/* rtl/core/sha_core.sv */
`timescale 1ns / 1ps
module sha_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic            init_chain,
    input  logic [511:0]    block,
    output logic            done,
    output logic [255:0]    chain
);

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [5:0]  rnd_reg;
    logic        run_reg;
    logic        fold_reg;

    logic [31:0] wt, s0, s1, t1, t2, wn, a, e;

    always_comb begin
        a  = v_reg[0];
        e  = v_reg[4];
        wt = w_reg[0];
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
           ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
           ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + s1 + w_reg[9];
        t1 = v_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::ROUND_K[rnd_reg] + wt;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fold_reg <= 1'b0;
            rnd_reg  <= '0;
            for (int j = 0; j < 8; j++) begin
                h_reg[j] <= sha_pkg::INIT_HASH[j];
            end
        end else begin
            fold_reg <= 1'b0;
            if (init_chain) begin
                for (int j = 0; j < 8; j++) begin
                    h_reg[j] <= sha_pkg::INIT_HASH[j];
                end
            end
            if (start) begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
                for (int j = 0; j < 16; j++) begin
                    w_reg[j] <= block[511 - 32*j -: 32];
                end
                for (int j = 0; j < 8; j++) begin
                    v_reg[j] <= h_reg[j];
                end
            end else if (run_reg) begin
                for (int j = 0; j < 15; j++) begin
                    w_reg[j] <= w_reg[j+1];
                end
                w_reg[15] <= wn;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                rnd_reg  <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    run_reg  <= 1'b0;
                    fold_reg <= 1'b1;
                end
            end else if (fold_reg) begin
                for (int j = 0; j < 8; j++) begin
                    h_reg[j] <= h_reg[j] + v_reg[j];
                end
            end
        end
    end

    assign done = fold_reg;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            chain[255 - 32*j -: 32] = h_reg[j];
        end
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !run_reg && !fold_reg) else $error("start while busy");
    a_fold_once: assert property (@(posedge aclk) disable iff (!aresetn)
        fold_reg |=> !fold_reg) else $error("fold repeated");
    a_fold_after: assert property (@(posedge aclk) disable iff (!aresetn)
        fold_reg |-> $past(run_reg) && $past(rnd_reg) == 6'd63) else $error("bad fold");
`endif

endmodule
